>>> hdl/assert_macros.svh
// assertion macros used by the wilder smoothing average core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/wsa_pkg.sv
// package with types and constants of the wilder smoothing average core
package wsa_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 11;
  localparam logic [CFG_W-1:0] PERIOD_RST = 11'd14;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> hdl/wsa_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, plus addend
module wsa_mul
  import wsa_pkg::*;
#(
  parameter int PW = 11,
  parameter int NW = 43
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] mcand,
  input  logic        [PW-1:0]     mplier,
  input  logic signed [DATA_W-1:0] addend,
  output logic signed [NW-1:0]     product,
  output logic                     done
);

  localparam int CNTW = $clog2(PW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [NW-1:0]     acc_r;
  logic [NW-1:0]     mcand_r;
  logic [PW-1:0]     mplier_r;
  logic [NW-1:0]     acc_nxt;

  // add the shifted multiplicand when the current multiplier bit is set
  assign acc_nxt = mplier_r[0] ? acc_r + mcand_r : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(PW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= {{(NW-DATA_W){addend[DATA_W-1]}}, addend};
      mcand_r  <= {{(NW-DATA_W){mcand[DATA_W-1]}}, mcand};
      mplier_r <= mplier;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[NW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[PW-1:1]};
    end
  end

  assign product = signed'(acc_r);
  assign done    = done_r;

endmodule

>>> hdl/wsa_div.sv
// bit-serial restoring divider, one quotient bit per cycle, truncates toward zero
module wsa_div
  import wsa_pkg::*;
#(
  parameter int PW = 11,
  parameter int NW = 43
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NW-1:0]     dividend,
  input  logic        [PW-1:0]     divisor,
  output logic signed [DATA_W-1:0] quot,
  output logic                     done
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic            neg_r;
  logic [NW-1:0]   q_r;
  logic [PW-1:0]   rem_r;
  logic [PW-1:0]   dvs_r;
  logic [PW:0]     trial;
  logic            qbit;
  logic [PW-1:0]   rem_nxt;
  logic [NW-1:0]   mag;
  logic [PW:0]     diff;

  assign mag   = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? diff[PW-1:0] : trial[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[NW-1];
      q_r   <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  // quotient magnitude never exceeds 2^31, so 32 bits carry the signed result
  assign quot = neg_r ? signed'(-q_r[DATA_W-1:0]) : signed'(q_r[DATA_W-1:0]);
  assign done = done_r;

endmodule

>>> hdl/wilder_smoothing_average_core.sv
// wilder smoothed moving average: warm-up sum, seed mean and serial smoothing
// warm-up samples give no result; a seed runs the sum through the divider and a
// smoothed sample runs through the bit-serial multiplier and then the
// one-bit-per-cycle divider (PW = clog2(MAX_PERIOD+1), NW = 32+PW); one
// request in flight at a time
// reset (rst_n low, synchronous) clears the series state and sets period to 14
`include "assert_macros.svh"
module wilder_smoothing_average_core
  import wsa_pkg::*;
#(
  parameter int MAX_PERIOD = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: period
  input  logic              cfg_wen,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // input requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] sample
  input  logic              in_tuser,   // [0] restart
  // results
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] average
  output logic              out_tuser   // [0] is_seed
);

  // period width, working numerator width and config compare width
  localparam int PW = $clog2(MAX_PERIOD + 1);
  localparam int NW = DATA_W + PW;
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_PERIOD);

  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          period_r;
  logic [PW-1:0]             cnt_r, cnt_nxt;
  logic signed [NW-1:0]      sum_r, sum_nxt;
  logic signed [DATA_W-1:0]  prev_r, prev_nxt;
  logic                      seed_r, seed_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]         out_avg_r;
  logic                      out_seed_r;

  logic [CW-1:0]             period_ext;
  logic [PW-1:0]             p_eff;
  logic                      accept;
  logic [PW-1:0]             cnt_base;
  logic signed [NW-1:0]      sum_base;
  logic signed [NW-1:0]      sample_ext;
  logic                      out_free;
  logic                      load_out;

  logic                      mul_start, mul_done;
  logic signed [NW-1:0]      mul_prod;
  logic                      div_start, div_done;
  logic signed [NW-1:0]      div_num;
  logic signed [DATA_W-1:0]  div_quot;

  // effective period: zero acts as one, large values clamp to MAX_PERIOD
  assign period_ext = CW'(period_r);
  always_comb begin
    if (period_ext == '0) begin
      p_eff = PW'(1);
    end else if (period_ext > MAXV) begin
      p_eff = PW'(MAX_PERIOD);
    end else begin
      p_eff = period_ext[PW-1:0];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;

  // restart clears the warm-up before the sample is counted
  assign cnt_base   = in_tuser ? '0 : cnt_r;
  assign sum_base   = in_tuser ? '0 : sum_r;
  assign sample_ext = {{(NW-DATA_W){in_tdata[DATA_W-1]}}, in_tdata};

  // sequencer: warm-up is summed in ST_IDLE, seed goes straight to the divider,
  // smoothing runs prev*(p-1)+x through the multiplier first
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    seed_nxt  = seed_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_num   = mul_prod;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_base < p_eff) begin
            sum_nxt = sum_base + sample_ext;
            cnt_nxt = cnt_base + 1'b1;
            if (cnt_nxt == p_eff) begin
              // last warm-up sample: plain mean is the seed
              div_start = 1'b1;
              div_num   = sum_nxt;
              seed_nxt  = 1'b1;
              state_nxt = ST_DIV;
            end
          end else begin
            cnt_nxt   = p_eff;
            sum_nxt   = sum_base;
            mul_start = 1'b1;
            seed_nxt  = 1'b0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to drain, then hand the result over
        if (out_free) begin
          load_out  = 1'b1;
          prev_nxt  = div_quot;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register keeps the finished result while the next sample is taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      period_r     <= PERIOD_RST;
      cnt_r        <= '0;
      sum_r        <= '0;
      prev_r       <= '0;
      seed_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      prev_r       <= prev_nxt;
      seed_r       <= seed_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wen) begin
        period_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_avg_r  <= div_quot;
      out_seed_r <= seed_r;
    end
  end

  wsa_mul #(
    .PW (PW),
    .NW (NW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (prev_r),
    .mplier  (p_eff - 1'b1),
    .addend  (signed'(in_tdata)),
    .product (mul_prod),
    .done    (mul_done)
  );

  wsa_div #(
    .PW (PW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (p_eff),
    .quot     (div_quot),
    .done     (div_done)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_avg_r;
  assign out_tuser  = out_seed_r;

  `ASSERT_IMPLY(a_mul_done_in_mul, clk, rst_n, mul_done, state_r == ST_MUL)
  `ASSERT_IMPLY(a_div_done_in_div, clk, rst_n, div_done, state_r == ST_DIV)
  `ASSERT_NEXT(a_result_loaded, clk, rst_n, load_out, out_tvalid_r && out_avg_r == $past(div_quot))

endmodule
